### sv/owtr_pkg.sv
package owtr_pkg;

  // Stream and config port widths
  localparam int unsigned S_TDATA_W  = 8;
  localparam int unsigned M_TDATA_W  = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // Config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_RESET_TAIL    = 3'd2,
    REG_WR1_LOW       = 3'd3,
    REG_WR0_LOW       = 3'd4,
    REG_RD_LOW        = 3'd5,
    REG_RD_SAMPLE     = 3'd6,
    REG_SLOT          = 3'd7
  } cfg_idx_e;

  // Config reset values (bus timing in 1 us ticks)
  localparam logic [9:0] RESET_LOW_DEF     = 10'd480;
  localparam logic [7:0] PRESENCE_WAIT_DEF = 8'd60;
  localparam logic [9:0] RESET_TAIL_DEF    = 10'd420;
  localparam logic [7:0] WR1_LOW_DEF       = 8'd10;
  localparam logic [7:0] WR0_LOW_DEF       = 8'd50;
  localparam logic [7:0] RD_LOW_DEF        = 8'd1;
  localparam logic [7:0] RD_SAMPLE_DEF     = 8'd5;
  localparam logic [7:0] SLOT_DEF          = 8'd60;

  // Device command bytes
  localparam logic [7:0] OP_SKIP_ROM = 8'hCC;
  localparam logic [7:0] OP_CONVERT  = 8'h44;
  localparam logic [7:0] OP_READ_PAD = 8'hBE;

  // Run status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_PRES1 = 2'd1;
  localparam logic [1:0] STAT_NO_PRES2 = 2'd2;
  localparam logic [1:0] STAT_BAD      = 2'd3;

  typedef struct packed {
    logic [9:0] reset_low;
    logic [7:0] presence_wait;
    logic [9:0] reset_tail;
    logic [7:0] wr1_low;
    logic [7:0] wr0_low;
    logic [7:0] rd_low;
    logic [7:0] rd_sample;
    logic [7:0] slot;
  } cfg_t;

  typedef enum logic [12:0] {
    PH_IDLE    = 13'b0000000000001,
    PH_R1_LOW  = 13'b0000000000010,
    PH_R1_WAIT = 13'b0000000000100,
    PH_R1_TAIL = 13'b0000000001000,
    PH_W_SKIP1 = 13'b0000000010000,
    PH_W_CONV  = 13'b0000000100000,
    PH_R2_LOW  = 13'b0000001000000,
    PH_R2_WAIT = 13'b0000010000000,
    PH_R2_TAIL = 13'b0000100000000,
    PH_W_SKIP2 = 13'b0001000000000,
    PH_W_READ  = 13'b0010000000000,
    PH_RD_LO   = 13'b0100000000000,
    PH_RD_HI   = 13'b1000000000000
  } phase_e;

  typedef struct packed {
    logic               pull_low;
    logic               busy;
    logic               done;
    logic [1:0]         status;
    logic signed [15:0] temperature;
  } res_t;

endpackage

### sv/owtr_cfg.sv
module owtr_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [owtr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [owtr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output owtr_pkg::cfg_t                      cfg_o
);
  import owtr_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_RESET_LOW:     cfg_d.reset_low     = cfg_data_i;
        REG_PRESENCE_WAIT: cfg_d.presence_wait = cfg_data_i[7:0];
        REG_RESET_TAIL:    cfg_d.reset_tail    = cfg_data_i;
        REG_WR1_LOW:       cfg_d.wr1_low       = cfg_data_i[7:0];
        REG_WR0_LOW:       cfg_d.wr0_low       = cfg_data_i[7:0];
        REG_RD_LOW:        cfg_d.rd_low        = cfg_data_i[7:0];
        REG_RD_SAMPLE:     cfg_d.rd_sample     = cfg_data_i[7:0];
        REG_SLOT:          cfg_d.slot          = cfg_data_i[7:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low     <= RESET_LOW_DEF;
      cfg_q.presence_wait <= PRESENCE_WAIT_DEF;
      cfg_q.reset_tail    <= RESET_TAIL_DEF;
      cfg_q.wr1_low       <= WR1_LOW_DEF;
      cfg_q.wr0_low       <= WR0_LOW_DEF;
      cfg_q.rd_low        <= RD_LOW_DEF;
      cfg_q.rd_sample     <= RD_SAMPLE_DEF;
      cfg_q.slot          <= SLOT_DEF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/owtr_step.sv
module owtr_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  owtr_pkg::cfg_t  cfg_i,
  input  logic            en_i,
  input  logic            kind_i,
  input  logic            bus_i,
  output owtr_pkg::res_t  res_o
);
  import owtr_pkg::*;

  phase_e             ph_q, ph_d;
  logic [9:0]         tick_q, tick_d;
  logic [2:0]         bit_q, bit_d;
  logic [7:0]         shift_q, shift_d;
  logic [7:0]         low_q, low_d;
  logic signed [15:0] temp_q, temp_d;
  logic [1:0]         stat_q, stat_d;

  logic [10:0] tick_inc;
  logic [9:0]  rst_len;
  logic [7:0]  slot_len;
  logic [7:0]  wr_low;
  logic [8:0]  sp_raw, slot_last, sp;
  logic        slot_end;
  logic [7:0]  shift_rd;
  logic        pull, done;

  always_comb begin
    tick_inc  = {1'b0, tick_q} + 11'd1;
    rst_len   = (cfg_i.reset_low == 10'd0) ? 10'd1 : cfg_i.reset_low;
    slot_len  = (cfg_i.slot == 8'd0) ? 8'd1 : cfg_i.slot;
    wr_low    = shift_q[0] ? cfg_i.wr1_low : cfg_i.wr0_low;
    sp_raw    = {1'b0, cfg_i.rd_low} + {1'b0, cfg_i.rd_sample};
    slot_last = {1'b0, slot_len} - 9'd1;
    sp        = (sp_raw > slot_last) ? slot_last : sp_raw;
    slot_end  = tick_inc >= {3'b000, slot_len};
    shift_rd  = shift_q;
    if (tick_q == {1'b0, sp}) begin
      shift_rd[bit_q] = shift_q[bit_q] | bus_i;
    end
  end

  always_comb begin
    ph_d    = ph_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    low_d   = low_q;
    temp_d  = temp_q;
    stat_d  = stat_q;
    pull    = 1'b0;
    done    = 1'b0;
    if (kind_i) begin
      ph_d    = PH_R1_LOW;
      tick_d  = '0;
      bit_d   = '0;
      shift_d = '0;
    end else begin
      unique case (ph_q)
        PH_IDLE: begin
        end
        PH_R1_LOW, PH_R2_LOW: begin
          pull   = 1'b1;
          tick_d = tick_inc[9:0];
          if (tick_inc >= {1'b0, rst_len}) begin
            ph_d   = (ph_q == PH_R1_LOW) ? PH_R1_WAIT : PH_R2_WAIT;
            tick_d = '0;
          end
        end
        PH_R1_WAIT, PH_R2_WAIT: begin
          if (tick_q >= {2'b00, cfg_i.presence_wait}) begin
            tick_d = '0;
            if (bus_i) begin
              // no presence pulse: abort the run
              stat_d = (ph_q == PH_R1_WAIT) ? STAT_NO_PRES1 : STAT_NO_PRES2;
              ph_d   = PH_IDLE;
              done   = 1'b1;
            end else if (cfg_i.reset_tail == 10'd0) begin
              ph_d    = (ph_q == PH_R1_WAIT) ? PH_W_SKIP1 : PH_W_SKIP2;
              bit_d   = '0;
              shift_d = OP_SKIP_ROM;
            end else begin
              ph_d = (ph_q == PH_R1_WAIT) ? PH_R1_TAIL : PH_R2_TAIL;
            end
          end else begin
            tick_d = tick_inc[9:0];
          end
        end
        PH_R1_TAIL, PH_R2_TAIL: begin
          tick_d = tick_inc[9:0];
          if (tick_inc >= {1'b0, cfg_i.reset_tail}) begin
            ph_d    = (ph_q == PH_R1_TAIL) ? PH_W_SKIP1 : PH_W_SKIP2;
            tick_d  = '0;
            bit_d   = '0;
            shift_d = OP_SKIP_ROM;
          end
        end
        PH_W_SKIP1, PH_W_CONV, PH_W_SKIP2, PH_W_READ: begin
          pull   = tick_q < {2'b00, wr_low};
          tick_d = tick_inc[9:0];
          if (slot_end) begin
            tick_d  = '0;
            shift_d = {1'b0, shift_q[7:1]};
            if (bit_q == 3'd7) begin
              bit_d = '0;
              if (ph_q == PH_W_SKIP1) begin
                ph_d    = PH_W_CONV;
                shift_d = OP_CONVERT;
              end else if (ph_q == PH_W_CONV) begin
                ph_d    = PH_R2_LOW;
                shift_d = '0;
              end else if (ph_q == PH_W_SKIP2) begin
                ph_d    = PH_W_READ;
                shift_d = OP_READ_PAD;
              end else begin
                ph_d    = PH_RD_LO;
                shift_d = '0;
              end
            end else begin
              bit_d = bit_q + 3'd1;
            end
          end
        end
        PH_RD_LO, PH_RD_HI: begin
          pull    = tick_q < {2'b00, cfg_i.rd_low};
          shift_d = shift_rd;
          tick_d  = tick_inc[9:0];
          if (slot_end) begin
            tick_d = '0;
            if (bit_q == 3'd7) begin
              bit_d   = '0;
              shift_d = '0;
              if (ph_q == PH_RD_LO) begin
                low_d = shift_rd;
                ph_d  = PH_RD_HI;
              end else begin
                temp_d = {shift_rd, low_q};
                stat_d = STAT_OK;
                ph_d   = PH_IDLE;
                done   = 1'b1;
              end
            end else begin
              bit_d = bit_q + 3'd1;
            end
          end
        end
        default: begin
          ph_d   = PH_IDLE;
          tick_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      low_q   <= '0;
      temp_q  <= '0;
      stat_q  <= STAT_OK;
    end else if (en_i) begin
      ph_q    <= ph_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      low_q   <= low_d;
      temp_q  <= temp_d;
      stat_q  <= stat_d;
    end
  end

  assign res_o.pull_low    = pull;
  assign res_o.busy        = ph_d != PH_IDLE;
  assign res_o.done        = done;
  assign res_o.status      = stat_d;
  assign res_o.temperature = temp_d;

endmodule

### sv/one_wire_temperature_read_master.sv
// One-wire bus master that reads a single temperature sensor.
//
// Input stream (s_axis_*): one transaction per 1 us tick or per start request.
//   tuser = kind (0 tick, 1 start), tdata[0] = sampled bus level (1 high).
// Output stream (m_axis_*): exactly one transaction per input transaction, in
//   order. tdata[0] says whether to hold the bus low for that tick; tlast marks
//   the transaction that ends a run (success or missing presence pulse).
// A start (re)launches the run: reset pulse + presence, skip-ROM + convert,
//   second reset + presence, skip-ROM + read-scratchpad, then 16 read slots.
//   Temperature is the raw signed value in 1/16 degree units.
// Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i at the
//   clock edge; write only while no transaction is in flight.
// Path: the input register holds the accepted transaction, then one state
//   update feeds the result register.
// Throughput: one transaction per cycle while m_axis_tready stays high; the state
//   update is a single pass of short logic, so every tick is taken back to back.
// Reset: idle, status ok, temperature zero, timing registers at defaults.
// Stall: while m_axis_tready is low the result holds; the input register
//   still takes one more transaction, then s_axis_tready drops.
module one_wire_temperature_read_master (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // config write port
  input  logic                                  cfg_we_i,
  input  logic [owtr_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [owtr_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [owtr_pkg::S_TDATA_W-1:0]        s_axis_tdata,  // [0] bus_sample, rest 0
  input  logic                                  s_axis_tuser,  // [0] kind
  // result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [owtr_pkg::M_TDATA_W-1:0]        m_axis_tdata,  // [0] pull_low, [1] busy_res,
                                                               // [3:2] status,
                                                               // [19:4] temperature, rest 0
  output logic                                  m_axis_tlast   // done_res
);
  import owtr_pkg::*;

  cfg_t cfg;
  res_t step_res;

  // input register
  logic in_v_q;
  logic in_kind_q;
  logic in_bus_q;

  // result register
  logic out_v_q;
  res_t out_q;

  logic advance;

  // Move the held transaction through the state update when the result
  // register is empty or being drained this cycle.
  assign advance       = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || advance;

  owtr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  owtr_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .en_i   (advance),
    .kind_i (in_kind_q),
    .bus_i  (in_bus_q),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind_q <= s_axis_tuser;
      in_bus_q  <= s_axis_tdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tlast  = out_q.done;
  assign m_axis_tdata  = {4'b0000, out_q.temperature, out_q.status,
                          out_q.busy, out_q.pull_low};

endmodule

### sv/owtr_checker.sv
module owtr_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  input  logic                                  s_axis_tready,
  input  logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  input  logic [owtr_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  input  logic                                  m_axis_tlast
);
  import owtr_pkg::*;

  // a run-ending result never reports the run as still going
  a_last_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[1])
    else $error("run end reported while busy");

  // status code is never STAT_BAD
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[3:2] != STAT_BAD)
    else $error("illegal status code");

  // a new result appears only after an input transaction passes the input register
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without input transaction");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind one_wire_temperature_read_master owtr_checker u_owtr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

### verif/one_wire_temperature_read_master_tb.sv
`timescale 1ns / 1ps

// Testbench for the one-wire temperature read master.
// Walks a short directed plan, then several timing settings with random
// read runs. Every result is checked against a typed-in value or an in-bench
// model of the bus master, kept in step as each input transaction is accepted.
module one_wire_temperature_read_master_tb;
  import owtr_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int          N_SETTINGS   = 8;

  // Timing sets: defaults, all at zero, all at max, and the tiny one most of the
  // directed plan runs under (one-tick resets, one-tick slots, a long write-0
  // low time and a read sample past the slot end).
  localparam cfg_t TIMING_DEF = '{RESET_LOW_DEF, PRESENCE_WAIT_DEF, RESET_TAIL_DEF,
                                  WR1_LOW_DEF, WR0_LOW_DEF, RD_LOW_DEF,
                                  RD_SAMPLE_DEF, SLOT_DEF};
  localparam cfg_t TIMING_ZERO = '0;
  localparam cfg_t TIMING_MAX  = '{10'd1023, 8'd255, 10'd1023, 8'd255, 8'd255,
                                   8'd255, 8'd255, 8'd255};
  localparam cfg_t TIMING_TINY = '{10'd0, 8'd0, 10'd0, 8'd0, 8'd255,
                                   8'd0, 8'd255, 8'd0};

  // Result shorthands for the directed plan: {pull, busy, done, status, temp}
  localparam res_t R_QUIET = '0;
  localparam res_t R_BUSY  = '{1'b0, 1'b1, 1'b0, STAT_OK, 16'sd0};
  localparam res_t R_PULL  = '{1'b1, 1'b1, 1'b0, STAT_OK, 16'sd0};

  // One plan row: optionally retime to the tiny set first, then send the
  // same item reps times. fixed rows carry a typed-in result; the others
  // are checked against the model.
  typedef struct packed {
    logic       retime;
    logic       kind;
    logic       bus;
    logic [7:0] reps;
    logic       fixed;
    res_t       want;
  } plan_row_t;

  localparam int PLAN_ROWS = 22;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // after reset, default timing
    '{1'b0, 1'b0, 1'b0, 8'd1,  1'b1, R_QUIET},   // tick while idle, bus low
    '{1'b0, 1'b0, 1'b1, 8'd1,  1'b1, R_QUIET},   // tick while idle, bus high
    '{1'b0, 1'b1, 1'b0, 8'd1,  1'b1, R_BUSY},    // start
    '{1'b0, 1'b0, 1'b1, 8'd1,  1'b1, R_PULL},    // first reset-pulse tick
    '{1'b0, 1'b1, 1'b1, 8'd1,  1'b1, R_BUSY},    // restart mid-run
    // tiny timing
    '{1'b1, 1'b1, 1'b0, 8'd1,  1'b1, R_BUSY},
    '{1'b0, 1'b0, 1'b0, 8'd1,  1'b1, R_PULL},    // zero reset low -> one tick
    '{1'b0, 1'b0, 1'b1, 8'd1,  1'b1,             // no presence, first reset
      '{1'b0, 1'b0, 1'b1, STAT_NO_PRES1, 16'sd0}},
    '{1'b0, 1'b1, 1'b1, 8'd1,  1'b1, '{1'b0, 1'b1, 1'b0, STAT_NO_PRES1, 16'sd0}},
    '{1'b0, 1'b0, 1'b1, 8'd1,  1'b1, '{1'b1, 1'b1, 1'b0, STAT_NO_PRES1, 16'sd0}},
    '{1'b0, 1'b0, 1'b0, 8'd1,  1'b1,             // presence, no tail
      '{1'b0, 1'b1, 1'b0, STAT_NO_PRES1, 16'sd0}},
    '{1'b0, 1'b0, 1'b1, 8'd16, 1'b0, R_QUIET},   // skip-ROM + convert slots
    '{1'b0, 1'b0, 1'b0, 8'd1,  1'b0, R_QUIET},   // second reset pulse
    '{1'b0, 1'b0, 1'b1, 8'd1,  1'b1,             // no presence, second reset
      '{1'b0, 1'b0, 1'b1, STAT_NO_PRES2, 16'sd0}},
    // full run reading all ones, then full run reading all zeros
    '{1'b0, 1'b1, 1'b0, 8'd1,  1'b0, R_QUIET},
    '{1'b0, 1'b0, 1'b0, 8'd36, 1'b0, R_QUIET},
    '{1'b0, 1'b0, 1'b1, 8'd15, 1'b0, R_QUIET},
    '{1'b0, 1'b0, 1'b1, 8'd1,  1'b1, '{1'b0, 1'b0, 1'b1, STAT_OK, -16'sd1}},
    '{1'b0, 1'b1, 1'b1, 8'd1,  1'b0, R_QUIET},
    '{1'b0, 1'b0, 1'b0, 8'd36, 1'b0, R_QUIET},
    '{1'b0, 1'b0, 1'b0, 8'd15, 1'b0, R_QUIET},
    '{1'b0, 1'b0, 1'b0, 8'd1,  1'b1, '{1'b0, 1'b0, 1'b1, STAT_OK, 16'sd0}}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;   // [0] bus_sample
  logic                  s_axis_tuser;   // [0] kind
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;   // [0] pull_low, [1] busy, [3:2] status,
                                         // [19:4] temperature
  logic                  m_axis_tlast;   // done

  // Bus master model state
  phase_e      ph;
  int          tick_cnt;
  logic [2:0]  bit_idx;
  logic [7:0]  shift_q;
  logic [7:0]  low_q;
  logic [15:0] temp_q;
  logic [1:0]  status_q;
  cfg_t        timing;

  res_t        owed_results[$];
  int          errors;
  int          items_sent;
  int          reads_ok;
  int          lost_first;
  int          lost_second;
  int unsigned cycles = 0;

  // Stimulus knobs
  logic        calm;          // no idling on either side while set
  int          miss_pct;      // chance the device stays silent at presence
  logic [15:0] read_target;   // value the device returns in the current run

  one_wire_temperature_read_master u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Bus master model
  // ---------------------------------------------------------------------
  function automatic void open_phase(phase_e p, logic [7:0] b);
    ph       = p;
    tick_cnt = 0;
    bit_idx  = 3'd0;
    shift_q  = b;
  endfunction

  function automatic int slot_len();
    return (timing.slot == 8'd0) ? 1 : int'(timing.slot);
  endfunction

  // Read-slot sample point, clamped to the last tick of the slot
  function automatic int sample_pos();
    int sp;
    sp = int'(timing.rd_low) + int'(timing.rd_sample);
    if (sp > slot_len() - 1) sp = slot_len() - 1;
    return sp;
  endfunction

  function automatic res_t predict_item(logic kind, logic bus);
    res_t r;
    int   len;
    logic b;
    logic fin;
    r   = '0;
    fin = 1'b0;
    if (kind) begin
      open_phase(PH_R1_LOW, 8'h00);
    end else begin
      case (ph)
        PH_R1_LOW, PH_R2_LOW: begin
          r.pull_low = 1'b1;
          len = (timing.reset_low == 10'd0) ? 1 : int'(timing.reset_low);
          tick_cnt++;
          if (tick_cnt >= len) begin
            ph       = (ph == PH_R1_LOW) ? PH_R1_WAIT : PH_R2_WAIT;
            tick_cnt = 0;
          end
        end
        PH_R1_WAIT, PH_R2_WAIT: begin
          if (tick_cnt >= int'(timing.presence_wait)) begin
            if (bus) begin
              status_q = (ph == PH_R1_WAIT) ? STAT_NO_PRES1 : STAT_NO_PRES2;
              ph       = PH_IDLE;
              tick_cnt = 0;
              fin      = 1'b1;
            end else if (timing.reset_tail == 10'd0) begin
              open_phase((ph == PH_R1_WAIT) ? PH_W_SKIP1 : PH_W_SKIP2, OP_SKIP_ROM);
            end else begin
              ph       = (ph == PH_R1_WAIT) ? PH_R1_TAIL : PH_R2_TAIL;
              tick_cnt = 0;
            end
          end else begin
            tick_cnt++;
          end
        end
        PH_R1_TAIL, PH_R2_TAIL: begin
          tick_cnt++;
          if (tick_cnt >= int'(timing.reset_tail))
            open_phase((ph == PH_R1_TAIL) ? PH_W_SKIP1 : PH_W_SKIP2, OP_SKIP_ROM);
        end
        PH_W_SKIP1, PH_W_CONV, PH_W_SKIP2, PH_W_READ: begin
          b = shift_q[0];
          r.pull_low = tick_cnt < int'(b ? timing.wr1_low : timing.wr0_low);
          tick_cnt++;
          if (tick_cnt >= slot_len()) begin
            tick_cnt = 0;
            shift_q  = shift_q >> 1;
            if (bit_idx == 3'd7) begin
              case (ph)
                PH_W_SKIP1: open_phase(PH_W_CONV, OP_CONVERT);
                PH_W_CONV:  open_phase(PH_R2_LOW, 8'h00);
                PH_W_SKIP2: open_phase(PH_W_READ, OP_READ_PAD);
                default:    open_phase(PH_RD_LO, 8'h00);
              endcase
            end else begin
              bit_idx++;
            end
          end
        end
        PH_RD_LO, PH_RD_HI: begin
          r.pull_low = tick_cnt < int'(timing.rd_low);
          if (tick_cnt == sample_pos()) shift_q[bit_idx] = shift_q[bit_idx] | bus;
          tick_cnt++;
          if (tick_cnt >= slot_len()) begin
            tick_cnt = 0;
            if (bit_idx == 3'd7) begin
              if (ph == PH_RD_LO) begin
                low_q = shift_q;
                open_phase(PH_RD_HI, 8'h00);
              end else begin
                temp_q   = {shift_q, low_q};
                status_q = STAT_OK;
                open_phase(PH_IDLE, 8'h00);
                fin = 1'b1;
              end
            end else begin
              bit_idx++;
            end
          end
        end
        default: begin
          ph       = PH_IDLE;
          tick_cnt = 0;
        end
      endcase
    end
    r.busy        = (ph != PH_IDLE);
    r.done        = fin;
    r.status      = status_q;
    r.temperature = temp_q;
    return r;
  endfunction

  // Device side: answers presence except at a miss_pct percent chance, and returns
  // the run's target value at each read sample point; noise elsewhere.
  function automatic logic pick_bus();
    if ((ph == PH_R1_WAIT || ph == PH_R2_WAIT) && tick_cnt >= int'(timing.presence_wait))
      return $urandom_range(99) < miss_pct;
    if ((ph == PH_RD_LO || ph == PH_RD_HI) && tick_cnt == sample_pos())
      return read_target[{ph == PH_RD_HI, bit_idx}];
    return 1'($urandom_range(1));
  endfunction

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------
  // Entered and left at a falling edge. tvalid stays high from one
  // transaction to the next unless an idle gap is taken.
  task automatic push_item(input logic kind, input logic bus, input logic fixed,
                           input res_t typed);
    res_t guess;
    while (!calm && $urandom_range(99) < 15) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(S_TDATA_W-1){1'b0}}, bus};
    do @(posedge clk_i); while (!s_axis_tready);
    guess = predict_item(kind, bus);
    owed_results.push_back(fixed ? typed : guess);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Stop sending and let every owed result come back before a retime
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_timing(input cfg_t c);
    cfg_idx_e        idx;
    logic [9:0]      v;
    for (int i = 0; i < 8; i++) begin
      idx = cfg_idx_e'(i);
      case (idx)
        REG_RESET_LOW:     v = c.reset_low;
        REG_PRESENCE_WAIT: v = {2'b00, c.presence_wait};
        REG_RESET_TAIL:    v = c.reset_tail;
        REG_WR1_LOW:       v = {2'b00, c.wr1_low};
        REG_WR0_LOW:       v = {2'b00, c.wr0_low};
        REG_RD_LOW:        v = {2'b00, c.rd_low};
        REG_RD_SAMPLE:     v = {2'b00, c.rd_sample};
        default:           v = {2'b00, c.slot};
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= v;
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    timing = c;
  endtask

  // Result side backpressure
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 15);
  end

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.pull_low    = m_axis_tdata[0];
      got.busy        = m_axis_tdata[1];
      got.status      = m_axis_tdata[3:2];
      got.temperature = m_axis_tdata[19:4];
      got.done        = m_axis_tlast;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing owed, expected none actual %h", $time, got);
      end else begin
        want = owed_results.pop_front();
        check_field("pull_low", want.pull_low, got.pull_low);
        check_field("busy", want.busy, got.busy);
        check_field("done", want.done, got.done);
        check_field("status", want.status, got.status);
        check_field("temperature", want.temperature, got.temperature);
        if (want.done) begin
          case (want.status)
            STAT_NO_PRES1: lost_first++;
            STAT_NO_PRES2: lost_second++;
            default:       reads_ok++;
          endcase
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    cfg_t c;
    int   budget;
    int   n;
    logic first;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_RESET_LOW;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    calm          = 1'b0;
    miss_pct      = 8;
    read_target   = '0;
    errors        = 0;
    items_sent    = 0;
    reads_ok      = 0;
    lost_first    = 0;
    lost_second   = 0;
    timing        = TIMING_DEF;
    ph            = PH_IDLE;
    tick_cnt      = 0;
    bit_idx       = '0;
    shift_q       = '0;
    low_q         = '0;
    temp_q        = '0;
    status_q      = STAT_OK;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed plan
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].retime) begin
        settle();
        write_timing(TIMING_TINY);
      end
      for (int k = 0; k < int'(PLAN[i].reps); k++)
        push_item(PLAN[i].kind, PLAN[i].bus, PLAN[i].fixed, PLAN[i].want);
    end

    // Random runs under a series of timing sets. Mostly well-formed runs
    // (device answers, returns a chosen value), with silent devices,
    // restarts mid-run and ticks while idle mixed in. Setting 3 runs with
    // no idling; setting 6 is the all-max extreme and mostly sees the long
    // reset phase.
    for (int p = 0; p < N_SETTINGS; p++) begin
      settle();
      case (p)
        0:       c = TIMING_DEF;
        1:       c = TIMING_ZERO;
        6:       c = TIMING_MAX;
        default: c = '{10'($urandom_range(4)), 8'($urandom_range(4)),
                       10'($urandom_range(4)), 8'($urandom_range(3)),
                       8'($urandom_range(3)), 8'($urandom_range(2)),
                       8'($urandom_range(3)), 8'($urandom_range(3))};
      endcase
      write_timing(c);
      calm     = (p == 3);
      miss_pct = (p == 6) ? 50 : 8;
      budget   = (p == 6) ? 300 : ((p < 2) ? 100 : 120);
      n        = 0;
      first    = 1'b1;
      while (n < budget) begin
        if (first || ((ph == PH_IDLE) ? ($urandom_range(99) < 80)
                                      : ($urandom_range(99) < 2))) begin
          case ($urandom_range(4))
            0:       read_target = 16'h0000;
            1:       read_target = 16'hFFFF;
            2:       read_target = 16'h8000;
            3:       read_target = 16'h7FFF;
            default: read_target = 16'($urandom_range(16'hFFFF));
          endcase
          n++;
          first = 1'b0;
          push_item(1'b1, 1'($urandom_range(1)), 1'b0, R_QUIET);
        end else begin
          if (ph != PH_IDLE) n++;
          push_item(1'b0, pick_bus(), 1'b0, R_QUIET);
        end
      end
    end

    // Drain, then report
    s_axis_tvalid <= 1'b0;
    calm = 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d transactions across %0d timing sets plus the directed plan.",
             items_sent, N_SETTINGS);
    $display("Runs ended: %0d with a reading, %0d silent at first reset, %0d at second.",
             reads_ok, lost_first, lost_second);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
